// ----- hw/rtl/sift_index_bit_selector_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sift index bit selector
// Concurrent checks used at the end of sib_back.
// ----------------------------------------------------------------------------
`ifndef SIFT_INDEX_BIT_SELECTOR_MACROS_SVH
`define SIFT_INDEX_BIT_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIB_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIB_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sib_pkg.sv -----
// ----------------------------------------------------------------------------
// sib_pkg
// Types and fixed constants shared by the sift index bit selector modules.
// ----------------------------------------------------------------------------
package sib_pkg;

    // Request type codes.
    localparam logic [1:0] REQ_BEGIN  = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_REMOTE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_WORD  = 2'd0;
    localparam logic [1:0] STATUS_FLUSH = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PROTOCOL_MODE = 1'b0;
    localparam logic CFG_DIFF_BITS     = 1'b1;

    // Protocol modes.
    localparam logic MODE_SERVICE = 1'b0;
    localparam logic MODE_BB84    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic       PROTOCOL_MODE_RESET = MODE_BB84;
    localparam logic [4:0] DIFF_BITS_RESET     = 5'd8;

    // One queued request.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] word_addr;
        logic [31:0] data_word;
        logic [21:0] entry_count;
    } sib_item_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic      valid;
        sib_item_t item;
    } sib_queue_t;

    // Configuration register values.
    typedef struct packed {
        logic       protocol_mode;
        logic [4:0] diff_bits;
    } sib_cfg_t;

endpackage

// ----- hw/rtl/sib_if.sv -----
// ----------------------------------------------------------------------------
// sib_if
// Valid/ready channel interfaces: request, result and configuration write.
// ----------------------------------------------------------------------------
interface sib_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] word_addr;
    logic [31:0] data_word;
    logic [21:0] local_entry_count;

    modport source (output valid, req_type, word_addr, data_word, local_entry_count,
                    input ready);
    modport sink   (input valid, req_type, word_addr, data_word, local_entry_count,
                    output ready);
endinterface

interface sib_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic [1:0]  status;
    logic [23:0] event_count;
    logic        out_last;

    modport source (output valid, out_word, status, event_count, out_last, input ready);
    modport sink   (input valid, out_word, status, event_count, out_last, output ready);
endinterface

interface sib_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sib_ram.sv -----
// ----------------------------------------------------------------------------
// sib_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module sib_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: a write, or a read into the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/sib_front.sv -----
// ----------------------------------------------------------------------------
// sib_front
// Accepts requests, drops those that have no effect, and queues the rest.
// ----------------------------------------------------------------------------
module sib_front
    import sib_pkg::*;
#(
    parameter int STORE_WORDS = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    sib_req_if.sink    req,
    input  logic       pop,
    output sib_queue_t queue
);

    sib_item_t   slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        accept;
    logic        keep;
    logic        push;
    logic        do_pop;
    sib_item_t   item_in;

    // Classify: unknown types and stores beyond the store are dropped here.
    always_comb
    begin
        case (req.req_type)
            REQ_BEGIN:  keep = 1'b1;
            REQ_STORE:  keep = (32'(req.word_addr) < 32'(STORE_WORDS));
            REQ_REMOTE: keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign item_in.op          = req.req_type;
    assign item_in.word_addr   = req.word_addr;
    assign item_in.data_word   = req.data_word;
    assign item_in.entry_count = req.local_entry_count;

    assign req.ready = (count_reg != 2'd2);
    assign accept    = req.valid && req.ready;
    assign push      = accept && keep;
    assign do_pop    = pop && (count_reg != 2'd0);

    // Two-entry queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign queue.valid = (count_reg != 2'd0);
    assign queue.item  = slot_reg[rd_ptr_reg];

endmodule

// ----- hw/rtl/sib_back.sv -----
// ----------------------------------------------------------------------------
// sib_back
// Epoch sequencer: field parsing, local lookup, output packing and results.
// ----------------------------------------------------------------------------
module sib_back
    import sib_pkg::*;
#(
    parameter int STORE_WORDS = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    input  sib_cfg_t   cfg_regs,
    input  sib_queue_t queue,
    output logic       pop,
    sib_res_if.source  res
);

`include "sift_index_bit_selector_macros.svh"

    localparam int AW = $clog2(STORE_WORDS);
    localparam int LW = $clog2(STORE_WORDS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PARSE = 2'd1;
    localparam logic [1:0] ST_PACK  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [35:0]   buf_reg, buf_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [31:0]   word_reg, word_next;
    logic [5:0]    rem_reg, rem_next;
    logic          esc_reg, esc_next;
    logic [3:0]    saved_reg, saved_next;
    logic [31:0]   idx_reg, idx_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic [31:0]   acc_reg, acc_next;
    logic [5:0]    fill_reg, fill_next;
    logic [23:0]   events_reg, events_next;
    logic          done_reg, done_next;
    logic [4:0]    pos_reg, pos_next;
    logic [3:0]    remote_reg, remote_next;
    logic          hold_valid_reg, hold_valid_next;
    logic [31:0]   hold_word_reg, hold_word_next;
    logic [1:0]    hold_status_reg, hold_status_next;
    logic [23:0]   hold_count_reg, hold_count_next;
    logic          out_valid_reg;
    logic [31:0]   out_word_reg;
    logic [1:0]    out_status_reg;
    logic [23:0]   out_count_reg;
    logic          out_last_reg;

    logic          bb84;
    logic [2:0]    base_bits;
    logic [4:0]    dbits;
    logic [5:0]    need;
    logic [5:0]    take;
    logic          absorb;
    logic [5:0]    shift;
    logic [67:0]   joined;
    logic [35:0]   field;
    logic [31:0]   short_diff;
    logic [31:0]   entry_diff;
    logic [3:0]    f_remote;
    logic [31:0]   idx_new;
    logic [33:0]   bit_pos;
    logic          out_range;
    logic [23:0]   scaled;
    logic [19:0]   words;
    logic [LW-1:0] limit_val;
    logic [31:0]   shifted;
    logic [7:0]    pat;
    logic [6:0]    width;
    logic [6:0]    amt;
    logic [63:0]   win;
    logic [5:0]    fill_sum;
    logic          go;
    logic          prod_valid;
    logic [31:0]   prod_word;
    logic [1:0]    prod_status;
    logic [23:0]   prod_count;
    logic          fin_push;
    logic          push;
    logic          ram_en;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata;

    sib_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (queue.item.data_word),
        .rdata (ram_rdata)
    );

    // Field geometry from the configuration.
    assign bb84      = (cfg_regs.protocol_mode == MODE_BB84);
    assign base_bits = bb84 ? 3'd0 : 3'd4;
    assign dbits     = (cfg_regs.diff_bits == 5'd0) ? 5'd1 : cfg_regs.diff_bits;
    assign need      = esc_reg ? 6'd32 : ({1'b0, dbits} + {3'd0, base_bits});

    // Take the bits that complete a field, or all that remain of the word.
    assign take   = (cnt_reg >= need) ? 6'd1 : (need - cnt_reg);
    assign absorb = (take > rem_reg);
    assign shift  = absorb ? rem_reg : take;
    assign joined = {buf_reg, word_reg} << shift;
    assign field  = joined[67:32] & ~(36'hF_FFFF_FFFF << need);

    // Field decoding: short difference, escape extension and remote bits.
    assign short_diff = (bb84 ? field[31:0] : field[35:4]) & ~(32'hFFFF_FFFF << dbits);
    assign f_remote   = bb84 ? 4'd0 : field[3:0];
    always_comb
    begin
        if (esc_reg)
        begin
            entry_diff = bb84 ? field[31:0] : {saved_reg, field[31:4]};
        end
        else
        begin
            entry_diff = short_diff;
        end
    end

    // Index step and range check against the epoch's word limit.
    assign idx_new   = idx_reg + entry_diff - 32'd2;
    assign bit_pos   = bb84 ? {2'b00, idx_new} : {idx_new, 2'b00};
    assign out_range = (32'(bit_pos[33:5]) >= 32'(limit_reg));

    // Word limit for a begin request.
    assign scaled    = bb84 ? {2'b00, queue.item.entry_count} : {queue.item.entry_count, 2'b00};
    assign words     = 20'((25'(scaled) + 25'd31) >> 5);
    assign limit_val = (32'(words) >= 32'(STORE_WORDS)) ? LW'(STORE_WORDS) : LW'(words);

    // Local bit selection and MSB-first packing.
    assign shifted  = ram_rdata << pos_reg;
    assign pat      = bb84 ? {7'd0, shifted[31]} : {shifted[31:28], remote_reg};
    assign width    = bb84 ? 7'd1 : 7'd8;
    assign amt      = 7'd64 - {1'b0, fill_reg} - width;
    assign win      = {acc_reg, 32'd0} | ({56'd0, pat} << amt);
    assign fill_sum = fill_reg + width[5:0];

    // The newest result waits in the hold register until the next one shows
    // whether it was the last of its transaction.
    assign go       = !hold_valid_reg || !out_valid_reg || res.ready;
    assign fin_push = (state_reg == ST_FIN) && hold_valid_reg && go;
    assign push     = (prod_valid && hold_valid_reg) || fin_push;

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        word_next   = word_reg;
        rem_next    = rem_reg;
        esc_next    = esc_reg;
        saved_next  = saved_reg;
        idx_next    = idx_reg;
        limit_next  = limit_reg;
        acc_next    = acc_reg;
        fill_next   = fill_reg;
        events_next = events_reg;
        done_next   = done_reg;
        pos_next    = pos_reg;
        remote_next = remote_reg;
        prod_valid  = 1'b0;
        prod_word   = 32'd0;
        prod_status = STATUS_WORD;
        prod_count  = 24'd0;
        pop         = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = AW'(queue.item.word_addr);

        case (state_reg)
            ST_IDLE:
            begin
                if (queue.valid)
                begin
                    pop = 1'b1;
                    case (queue.item.op)
                        REQ_BEGIN:
                        begin
                            buf_next    = 36'd0;
                            cnt_next    = 6'd0;
                            esc_next    = 1'b0;
                            saved_next  = 4'd0;
                            idx_next    = 32'd0;
                            acc_next    = 32'd0;
                            fill_next   = 6'd0;
                            events_next = 24'd0;
                            limit_next  = limit_val;
                            done_next   = 1'b0;
                        end
                        REQ_STORE:
                        begin
                            ram_en = 1'b1;
                            ram_we = 1'b1;
                        end
                        REQ_REMOTE:
                        begin
                            if (!done_reg)
                            begin
                                word_next  = queue.item.data_word;
                                rem_next   = 6'd32;
                                state_next = ST_PARSE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PARSE:
            begin
                if (go)
                begin
                    if (rem_reg == 6'd0)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (absorb)
                    begin
                        buf_next   = joined[67:32];
                        cnt_next   = cnt_reg + rem_reg;
                        word_next  = joined[31:0];
                        rem_next   = 6'd0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        buf_next  = 36'd0;
                        cnt_next  = 6'd0;
                        word_next = joined[31:0];
                        rem_next  = rem_reg - take;
                        if (!esc_reg && short_diff == 32'd0)
                        begin
                            // Escape: a full extension word follows.
                            esc_next   = 1'b1;
                            saved_next = f_remote;
                        end
                        else if (!esc_reg && short_diff == 32'd1)
                        begin
                            // End of epoch: flush the partial word.
                            prod_valid  = 1'b1;
                            prod_word   = acc_reg;
                            prod_status = STATUS_FLUSH;
                            prod_count  = events_reg;
                            done_next   = 1'b1;
                            state_next  = ST_FIN;
                        end
                        else
                        begin
                            esc_next = 1'b0;
                            idx_next = idx_new;
                            if (out_range)
                            begin
                                prod_valid  = 1'b1;
                                prod_status = STATUS_RANGE;
                                prod_count  = events_reg;
                                done_next   = 1'b1;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                pos_next    = bit_pos[4:0];
                                remote_next = f_remote;
                                ram_en      = 1'b1;
                                ram_addr    = bit_pos[AW+4:5];
                                state_next  = ST_PACK;
                            end
                        end
                    end
                end
            end
            ST_PACK:
            begin
                if (go)
                begin
                    events_next = events_reg + 24'd1;
                    if (fill_sum >= 6'd32)
                    begin
                        prod_valid  = 1'b1;
                        prod_word   = win[63:32];
                        prod_status = STATUS_WORD;
                        acc_next    = win[31:0];
                        fill_next   = fill_sum - 6'd32;
                    end
                    else
                    begin
                        acc_next  = win[63:32];
                        fill_next = fill_sum;
                    end
                    state_next = ST_PARSE;
                end
            end
            ST_FIN:
            begin
                if (!hold_valid_reg || go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold register for the newest result.
    always_comb
    begin
        hold_valid_next  = hold_valid_reg;
        hold_word_next   = hold_word_reg;
        hold_status_next = hold_status_reg;
        hold_count_next  = hold_count_reg;
        if (prod_valid)
        begin
            hold_valid_next  = 1'b1;
            hold_word_next   = prod_word;
            hold_status_next = prod_status;
            hold_count_next  = prod_count;
        end
        else if (fin_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            buf_reg        <= 36'd0;
            cnt_reg        <= 6'd0;
            rem_reg        <= 6'd0;
            esc_reg        <= 1'b0;
            saved_reg      <= 4'd0;
            idx_reg        <= 32'd0;
            limit_reg      <= '0;
            acc_reg        <= 32'd0;
            fill_reg       <= 6'd0;
            events_reg     <= 24'd0;
            done_reg       <= 1'b1;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            rem_reg        <= rem_next;
            esc_reg        <= esc_next;
            saved_reg      <= saved_next;
            idx_reg        <= idx_next;
            limit_reg      <= limit_next;
            acc_reg        <= acc_next;
            fill_reg       <= fill_next;
            events_reg     <= events_next;
            done_reg       <= done_next;
            hold_valid_reg <= hold_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        word_reg        <= word_next;
        pos_reg         <= pos_next;
        remote_reg      <= remote_next;
        hold_word_reg   <= hold_word_next;
        hold_status_reg <= hold_status_next;
        hold_count_reg  <= hold_count_next;
        if (push)
        begin
            out_word_reg   <= hold_word_reg;
            out_status_reg <= hold_status_reg;
            out_count_reg  <= hold_count_reg;
            out_last_reg   <= fin_push;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_word    = out_word_reg;
    assign res.status      = out_status_reg;
    assign res.event_count = out_count_reg;
    assign res.out_last    = out_last_reg;

    // A lookup is always issued by the parse step just before.
    `SIB_ASSERT_NOW(a_pack_after_parse, clk, rst_n, state_reg == ST_PACK,
        $past(state_reg) == ST_PARSE, "pack step without a preceding lookup")
    // The packer never holds a full word.
    `SIB_ASSERT_NOW(a_fill_partial, clk, rst_n, 1'b1, fill_reg < 6'd32,
        "output accumulator overfilled")
    // The held result leaves as the last one of its transaction.
    `SIB_ASSERT_NEXT(a_fin_last, clk, rst_n, fin_push, out_valid_reg && out_last_reg,
        "final result not marked last")
    // A flush or range result closes the epoch.
    `SIB_ASSERT_NEXT(a_close_epoch, clk, rst_n,
        prod_valid && (prod_status == STATUS_FLUSH || prod_status == STATUS_RANGE),
        done_reg, "epoch still open after its closing result")

endmodule

// ----- hw/rtl/sift_index_bit_selector.sv -----
// ----------------------------------------------------------------------------
// sift_index_bit_selector
// Sifts locally stored entries against a stream of remote index words.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (begin epoch, store local word, remote index
// word), results leave on res, and cfg writes protocol_mode (index 0) and
// diff_bits (index 1) while the block is idle; cfg is always ready.
// A begin or store transaction gives no result. A remote word runs through
// the field parser, with one local store read per entry and the packer
// after each read, and an escape field takes its own parse step.
// A two-entry request queue lets the front accept while the back works,
// and the results go through a hold stage and an output register.
// The last result of a transaction has out_last set, so one result lags
// until the block knows whether more follow.
// When res is stalled the back end stops at its next result; the queue
// keeps accepting until it is full. Reset clears all control state and
// closes the epoch; the local store is not cleared and holds garbage
// until written.
// ----------------------------------------------------------------------------
module sift_index_bit_selector
    import sib_pkg::*;
#(
    parameter int STORE_WORDS = 65536
) (
    input logic       clk,
    input logic       rst_n,
    sib_req_if.sink   req,
    sib_res_if.source res,
    sib_cfg_if.sink   cfg
);

    logic       mode_reg;
    logic [4:0] diff_bits_reg;
    sib_cfg_t   cfg_regs;
    sib_queue_t queue;
    logic       pop;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= PROTOCOL_MODE_RESET;
            diff_bits_reg <= DIFF_BITS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PROTOCOL_MODE: mode_reg      <= cfg.data[0];
                CFG_DIFF_BITS:     diff_bits_reg <= cfg.data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_regs.protocol_mode = mode_reg;
    assign cfg_regs.diff_bits     = diff_bits_reg;

    sib_front #(
        .STORE_WORDS (STORE_WORDS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (pop),
        .queue (queue)
    );

    sib_back #(
        .STORE_WORDS (STORE_WORDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .queue    (queue),
        .pop      (pop),
        .res      (res)
    );

endmodule

// ----- sim/sib_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_checker
// Watches the request, result and configuration channels of the sift index
// bit selector. It keeps its own copy of the epoch state and predicts the
// packed words and status results of every accepted request. It then
// compares each result transaction in order against those predictions.
// ----------------------------------------------------------------------------
module sib_checker
    import sib_pkg::*;
#(
    parameter int STORE_WORDS = 65536
) (
    input  logic clk,
    input  logic rst_n,
    sib_req_if   req,
    sib_res_if   res,
    sib_cfg_if   cfg,
    output int   pending,
    output int   fail_count,
    output int   results_checked
);

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
        logic [23:0] count;
        logic        last;
    } sift_result_t;

    sift_result_t expected_q[$];
    sift_result_t batch_q[$];

    // Shadow configuration and epoch state.
    logic        mode;
    logic [4:0]  dbits;
    logic [31:0] store_mem [0:STORE_WORDS-1];
    logic [63:0] bit_buf;
    int unsigned bit_cnt;
    logic        esc_pending;
    logic [3:0]  saved_base;
    logic [31:0] entry_idx;
    int unsigned word_limit;
    logic [31:0] acc;
    int unsigned fill;
    logic [23:0] events;
    logic        done;

    task automatic add_result(input logic [31:0] w, input logic [1:0] st,
                              input logic [23:0] cnt);
        sift_result_t r;
        if (batch_q.size() < 10)
        begin
            r.word   = w;
            r.status = st;
            r.count  = cnt;
            r.last   = 1'b0;
            batch_q.push_back(r);
        end
    endtask

    task automatic clear_epoch();
        bit_buf     = '0;
        bit_cnt     = 0;
        esc_pending = 1'b0;
        saved_base  = '0;
        entry_idx   = '0;
        acc         = '0;
        fill        = 0;
        events      = '0;
    endtask

    // One entry: advance the index, look up the local bits and pack them.
    task automatic pick_entry(input logic [31:0] diff, input logic [3:0] remote);
        int unsigned lb;
        int unsigned w;
        logic [63:0] k;
        logic [31:0] loc;
        logic [31:0] pat;
        logic [63:0] win;
        int unsigned pos;
        lb = mode ? 1 : 4;
        w  = mode ? 1 : 8;
        entry_idx = entry_idx + diff - 32'd2;
        k = 64'(entry_idx) * 64'(lb);
        if ((k >> 5) >= 64'(word_limit) || (k >> 5) >= 64'(STORE_WORDS))
        begin
            add_result('0, STATUS_RANGE, events);
            done = 1'b1;
            return;
        end
        pos = int'(k[4:0]);
        loc = (store_mem[k >> 5] >> (32 - lb - pos)) & ((32'd1 << lb) - 32'd1);
        pat = mode ? loc : {24'd0, loc[3:0], remote};
        win = {acc, 32'd0} | (64'(pat) << (64 - fill - w));
        fill = fill + w;
        if (fill >= 32)
        begin
            add_result(win[63:32], STATUS_WORD, '0);
            win  = win << 32;
            fill = fill - 32;
        end
        acc    = win[63:32];
        events = events + 24'd1;
    endtask

    // One complete field: escape, end of epoch or entry.
    task automatic take_field(input logic [31:0] v);
        int unsigned bb;
        int unsigned db;
        logic [31:0] pmask;
        logic [31:0] diff;
        logic [3:0]  remote;
        bb    = mode ? 0 : 4;
        db    = (dbits != 0) ? dbits : 1;
        pmask = (32'd1 << bb) - 32'd1;
        remote = 4'(v & pmask);
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            diff = (bb != 0) ? ((v >> 4) | {saved_base, 28'd0}) : v;
            pick_entry(diff, remote);
            return;
        end
        diff = 32'((64'(v) >> bb) & ((64'd1 << db) - 64'd1));
        if (diff == 32'd0)
        begin
            esc_pending = 1'b1;
            saved_base  = remote;
        end
        else if (diff == 32'd1)
        begin
            add_result(acc, STATUS_FLUSH, events);
            done = 1'b1;
        end
        else
        begin
            pick_entry(diff, remote);
        end
    endtask

    // Works out every result of one accepted request.
    task automatic predict_request(input logic [1:0] op, input logic [15:0] addr,
                                   input logic [31:0] data, input logic [21:0] cnt);
        logic [63:0] words;
        int unsigned need;
        int unsigned bb;
        logic [31:0] v;
        logic [63:0] hi;
        batch_q.delete();
        if (op == REQ_BEGIN)
        begin
            words = (64'(cnt) * (mode ? 64'd1 : 64'd4) + 64'd31) >> 5;
            clear_epoch();
            word_limit = (words > 64'(STORE_WORDS)) ? STORE_WORDS : int'(words);
            done = 1'b0;
        end
        else if (op == REQ_STORE)
        begin
            if (int'(addr) < STORE_WORDS)
                store_mem[addr] = data;
        end
        else if (op == REQ_REMOTE)
        begin
            for (int b = 31; b >= 0 && !done; b--)
            begin
                bit_buf = ((bit_buf << 1) | 64'(data[b])) & 64'hF_FFFF_FFFF;
                bit_cnt++;
                need = esc_pending ? 32 : (((dbits != 0) ? dbits : 1) + (mode ? 0 : 4));
                if (bit_cnt >= need)
                begin
                    v  = 32'(bit_buf & ((64'd1 << need) - 64'd1));
                    hi = (need > 32) ? ((bit_buf >> 32) & ((64'd1 << (need - 32)) - 64'd1))
                                     : 64'd0;
                    bit_buf = '0;
                    bit_cnt = 0;
                    if (hi != 0 && !esc_pending)
                    begin
                        bb = mode ? 0 : 4;
                        pick_entry(32'(({hi[31:0], v}) >> bb), 4'(v & ((32'd1 << bb) - 1)));
                    end
                    else
                    begin
                        take_field(v);
                    end
                end
            end
        end
        if (batch_q.size() > 0)
            batch_q[batch_q.size() - 1].last = 1'b1;
        foreach (batch_q[i])
            expected_q.push_back(batch_q[i]);
    endtask

    // Follow configuration writes, requests and results at every edge.
    always @(posedge clk)
    begin
        sift_result_t exp_r;
        if (!rst_n)
        begin
            mode       = PROTOCOL_MODE_RESET;
            dbits      = DIFF_BITS_RESET;
            clear_epoch();
            word_limit = 0;
            done       = 1'b1;
            expected_q.delete();
            fail_count      <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_PROTOCOL_MODE)
                    mode = cfg.data[0];
                else
                    dbits = cfg.data[4:0];
            end
            if (req.valid && req.ready)
                predict_request(req.req_type, req.word_addr, req.data_word,
                                req.local_entry_count);
            if (res.valid && res.ready)
            begin
                results_checked <= results_checked + 1;
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: result with nothing expected: word %h status %0d",
                                 res.out_word, res.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (res.out_word !== exp_r.word || res.status !== exp_r.status ||
                        res.event_count !== exp_r.count || res.out_last !== exp_r.last)
                    begin
                        if (fail_count < 10)
                            $display({"ERROR: result mismatch: expected word %h status %0d ",
                                      "count %0d last %0d, got word %h status %0d ",
                                      "count %0d last %0d"},
                                     exp_r.word, exp_r.status, exp_r.count, exp_r.last,
                                     res.out_word, res.status, res.event_count,
                                     res.out_last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ----- sim/sift_index_bit_selector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sift_index_bit_selector_tb
// Drives whole sift epochs into the block: a begin, the local entry words,
// then a remote bit stream of short, escaped and closing fields built to
// hit written entries, with some runs past the local range. Both channels
// idle at random, and the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module sift_index_bit_selector_tb;
    import sib_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // Request type code that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Cycles to wait after the last result before a register write. Up to
    // three remote words can still be in flight with no result left.
    localparam int QUIET_CYCLES = 200;

    logic clk;
    logic rst_n;

    sib_req_if req_ch ();
    sib_res_if res_ch ();
    sib_cfg_if cfg_ch ();

    int pending;
    int fail_count;
    int results_checked;

    sift_index_bit_selector u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    sib_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .res             (res_ch),
        .cfg             (cfg_ch),
        .pending         (pending),
        .fail_count      (fail_count),
        .results_checked (results_checked)
    );

    // Generator view of the configuration and the current epoch.
    logic        cur_mode;
    logic [4:0]  cur_db;
    bit          stream_q[$];
    int          tx_idle;
    int          rx_idle;
    int          hold_request;
    int          hold_seen;
    int          hold_left;
    int          items_sent;
    int          epochs_run;
    int          cfg_writes;
    int          cycles;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Overall time limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sift_index_bit_selector test failed");
            $finish;
        end
    end

    // Result side: random stalls plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = 300;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // One request transaction, with random idle cycles ahead of it.
    task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [31:0] data, input logic [21:0] cnt);
        while ($urandom_range(99) < tx_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.req_type          <= op;
        req_ch.word_addr         <= addr;
        req_ch.data_word         <= data;
        req_ch.local_entry_count <= cnt;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering requests until every predicted result has arrived.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Both register writes, done only once the block has gone quiet.
    task automatic set_config(input logic mode, input logic [4:0] db);
        drain_results();
        repeat (QUIET_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PROTOCOL_MODE;
        cfg_ch.data  <= {31'd0, mode};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= CFG_DIFF_BITS;
        cfg_ch.data  <= {27'd0, db};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_mode = mode;
        cur_db   = db;
        cfg_writes += 2;
    endtask

    task automatic push_bits(input logic [31:0] v, input int w);
        for (int i = w - 1; i >= 0; i--)
            stream_q.push_back(v[i]);
    endtask

    // One epoch: begin, local words, then a field stream cut into words.
    task automatic run_epoch(input int max_entries, input int n_fields,
                             input bit with_error, input bit with_end);
        int unsigned lb;
        int unsigned db;
        int unsigned n;
        int unsigned lim;
        int unsigned slots;
        int unsigned t;
        logic [31:0] idx;
        logic [31:0] diff;
        logic [3:0]  rem;
        logic [31:0] w;
        lb = cur_mode ? 1 : 4;
        db = (cur_db != 0) ? cur_db : 1;
        // An abandoned begin with an arbitrary count now and then.
        if ($urandom_range(9) == 0)
            send_item(REQ_BEGIN, 16'($urandom), $urandom, 22'($urandom));
        n = $urandom_range(1, max_entries);
        send_item(REQ_BEGIN, 16'($urandom), $urandom, 22'(n));
        lim = (n * lb + 31) / 32;
        for (int a = 0; a < lim; a++)
            send_item(REQ_STORE, 16'(a), $urandom, 22'($urandom));
        if ($urandom_range(5) == 0)
            send_item(REQ_STORE, 16'($urandom), $urandom, 22'($urandom));
        slots = lim * 32 / lb;
        idx = '0;
        stream_q.delete();
        for (int f = 0; f < n_fields; f++)
        begin
            if (with_error && f == n_fields - 1)
                t = slots + $urandom_range(0, 5000);
            else if ($urandom_range(2) != 0)
            begin
                t = idx + $urandom_range(0, 3);
                if (t >= slots)
                    t = $urandom_range(0, slots - 1);
            end
            else
                t = $urandom_range(0, slots - 1);
            diff = t - idx + 32'd2;
            rem  = 4'($urandom);
            if (diff >= 2 && 64'(diff) < (64'd1 << db) && $urandom_range(7) != 0)
            begin
                push_bits(diff, db);
                if (!cur_mode)
                    push_bits(32'(rem), 4);
            end
            else if (cur_mode)
            begin
                push_bits(0, db);
                push_bits(diff, 32);
            end
            else
            begin
                push_bits(0, db);
                push_bits(32'(diff[31:28]), 4);
                push_bits({diff[27:0], rem}, 32);
            end
            idx = t;
        end
        if (with_end)
        begin
            push_bits(32'd1, db);
            if (!cur_mode)
                push_bits($urandom, 4);
        end
        while (stream_q.size() % 32 != 0)
            stream_q.push_back(1'($urandom));
        while (stream_q.size() > 0)
        begin
            for (int i = 31; i >= 0; i--)
                w[i] = stream_q.pop_front();
            send_item(REQ_REMOTE, 16'($urandom), w, 22'($urandom));
        end
        // Stray traffic after the stream: remote noise or an unused code.
        if ($urandom_range(3) == 0)
            send_item(REQ_REMOTE, 16'($urandom), $urandom, 22'($urandom));
        if ($urandom_range(15) == 0)
            send_item(REQ_UNUSED, 16'($urandom), $urandom, 22'($urandom));
        epochs_run++;
    endtask

    task automatic random_config();
        logic [4:0] db;
        case ($urandom_range(5))
            0: db = 5'd0;
            1: db = 5'd1;
            2: db = 5'd31;
            3: db = 5'd2;
            default: db = 5'($urandom_range(2, 12));
        endcase
        set_config(1'($urandom), db);
    endtask

    task automatic random_epochs(input int item_goal);
        while (items_sent < item_goal)
        begin
            if ($urandom_range(3) == 0)
                random_config();
            run_epoch(($urandom_range(4) == 0) ? 1 : (cur_mode ? 256 : 64),
                      $urandom_range(1, 12), $urandom_range(7) == 0,
                      $urandom_range(9) != 0);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n        = 1'b0;
        cycles       = 0;
        hold_request = 0;
        hold_seen    = 0;
        hold_left    = 0;
        items_sent   = 0;
        epochs_run   = 0;
        cfg_writes   = 0;
        cur_mode     = PROTOCOL_MODE_RESET;
        cur_db       = DIFF_BITS_RESET;
        tx_idle      = 19;
        rx_idle      = 76;
        req_ch.valid             <= 1'b0;
        req_ch.req_type          <= REQ_BEGIN;
        req_ch.word_addr         <= '0;
        req_ch.data_word         <= '0;
        req_ch.local_entry_count <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_PROTOCOL_MODE;
        cfg_ch.data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: traffic outside an epoch, extreme words and settings.
        send_item(REQ_REMOTE, 16'hFFFF, 32'hFFFF_FFFF, 22'h3F_FFFF);
        send_item(REQ_UNUSED, 16'h0000, 32'h0000_0000, 22'h00_0000);
        send_item(REQ_STORE, 16'hFFFF, 32'hFFFF_FFFF, 22'd0);
        run_epoch(40, 6, 1'b1, 1'b1);
        run_epoch(256, 10, 1'b0, 1'b1);
        set_config(MODE_SERVICE, 5'd31);
        run_epoch(64, 4, 1'b0, 1'b1);
        set_config(MODE_SERVICE, 5'd0);
        run_epoch(16, 3, 1'b0, 1'b0);
        set_config(MODE_BB84, 5'd1);
        run_epoch(64, 3, 1'b1, 1'b1);
        set_config(MODE_SERVICE, 5'd2);

        // Sender lightly idle, receiver mostly stalled, one long hold-off.
        random_epochs(100);
        hold_request = hold_request + 1;
        random_epochs(170);

        // Sender mostly idle, receiver lightly stalled, one full drain.
        tx_idle = 76;
        rx_idle = 19;
        random_epochs(240);
        drain_results();
        random_epochs(310);

        // No idling on either side.
        tx_idle = 0;
        rx_idle = 0;
        random_epochs(430);

        drain_results();
        repeat (50) @(posedge clk);
        $display("Covered %0d requests over %0d epochs, %0d register writes.",
                 items_sent, epochs_run, cfg_writes);
        $display("Checked %0d results, %0d failures.", results_checked, fail_count);
        if (fail_count == 0)
            $display("sift_index_bit_selector test passed");
        else
            $display("sift_index_bit_selector test failed");
        $finish;
    end

endmodule
